[rtl/core/sorted_value_table_top_macros.svh]
// ----------------------------------------------------------------------------
// Sorted value table: assertion macros
// Shared property forms for the sorted value table checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_VALUE_TABLE_TOP_MACROS_SVH
`define SORTED_VALUE_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SVT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SVT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/svt_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted value table package
// Sizes, opcode and status codes, and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package svt_pkg;

   localparam int CAPACITY = 32;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int ENTRY_COUNT_W = 6;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_DELETE = 2'd2,
      OP_POP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // Command seen by every cell in the chain during one transfer.
   typedef struct packed {
      logic                      ins;
      logic                      del;
      logic                      pop;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

[rtl/core/svt_req_if.sv]
// ----------------------------------------------------------------------------
// Sorted value table request channel
// Valid/ready channel carrying an opcode and an operand value.
// ----------------------------------------------------------------------------
interface svt_req_if import svt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                opcode;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

[rtl/core/svt_rsp_if.sv]
// ----------------------------------------------------------------------------
// Sorted value table response channel
// Valid/ready channel carrying status, popped value and entry count.
// ----------------------------------------------------------------------------
interface svt_rsp_if import svt_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic signed [VALUE_W-1:0] popped_value;
   logic [ENTRY_COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output popped_value,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input popped_value,
                   input entry_count, output ready);
endinterface

[rtl/core/svt_cell.sv]
// ----------------------------------------------------------------------------
// Sorted value table cell
// One slot of the sorted chain: compares against the broadcast value and
// holds, loads, or takes a neighbor's value.
// ----------------------------------------------------------------------------
module svt_cell import svt_pkg::*; (
   input  logic                      clock,
   input  cell_cmd_type              cmd,
   input  logic                      occupied,
   input  logic                      left_lt,
   input  logic signed [VALUE_W-1:0] left_value,
   input  logic signed [VALUE_W-1:0] right_value,
   output logic                      lt,
   output logic                      eq,
   output logic signed [VALUE_W-1:0] value
);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   assign lt    = occupied && (value_ff < cmd.value);
   assign eq    = occupied && (value_ff == cmd.value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         // the first slot not below the new value takes it; slots after it
         // move one place up
         if (!lt) begin
            value_in = left_lt ? cmd.value : left_value;
         end
      end else if (cmd.pop) begin
         value_in = right_value;
      end else if (cmd.del) begin
         if (!lt) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[rtl/core/sorted_value_table_top.sv]
// ----------------------------------------------------------------------------
// Sorted value table
// Holds up to CAPACITY signed values in ascending order in a chain of cells;
// insert, search, delete and pop each finish in one transfer.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries opcode (insert, search, delete, pop) and value. rsp_chan
//   returns one response per request: status, popped_value (zero unless a pop
//   succeeded) and entry_count after the operation.
//   The table updates at the request transfer and the response sits in an
//   output register from the next cycle on.
//   Throughput is one request per cycle while the receiver takes each response.
//   Every cell compares its entry with the broadcast value in parallel, so the
//   chain update at each request transfer sets the rate; insert ripples
//   nothing, each cell looks only at its neighbors.
//   When the receiver stalls, the response register holds and req_chan.ready
//   drops until the held response is taken (it stays high while the response
//   is taken in the same cycle).
//   Reset clears the entry count and the response valid; cell contents are
//   left as they are and are never read until written.
// ----------------------------------------------------------------------------
`include "sorted_value_table_top_macros.svh"

module sorted_value_table_top import svt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   svt_req_if.sink    req_chan,
   svt_rsp_if.source  rsp_chan
);

   // Handshake and decode
   logic       accept;
   opcode_type op;
   logic       full;
   logic       empty;
   logic       hit;

   // Chain wiring
   cell_cmd_type              cmd;
   logic [CAPACITY-1:0]       lt_vec;
   logic [CAPACITY-1:0]       eq_vec;
   logic signed [VALUE_W-1:0] cell_value [CAPACITY];

   // Count and response registers
   logic [COUNT_W-1:0]        count_ff;
   logic [COUNT_W-1:0]        count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   status_type                status_ff;
   status_type                status_in;
   logic signed [VALUE_W-1:0] popped_ff;
   logic signed [VALUE_W-1:0] popped_in;
   logic [COUNT_W-1:0]        rsp_count_ff;

   // Take a new request whenever the output register is free or draining.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign op             = opcode_type'(req_chan.opcode);

   assign full  = (count_ff >= COUNT_W'(CAPACITY));
   assign empty = (count_ff == '0);
   // Entries are sorted, so any match means one sits right at the boundary.
   assign hit   = |eq_vec;

   assign cmd.ins   = accept && (op == OP_INSERT) && !full;
   assign cmd.del   = accept && (op == OP_DELETE) && hit;
   assign cmd.pop   = accept && (op == OP_POP) && !empty;
   assign cmd.value = req_chan.value;

   // Build the chain: slot 0 sees an always-below left neighbor so an insert
   // in front of everything lands there; the last slot refills from itself.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      left_lt;
      logic signed [VALUE_W-1:0] left_value;
      logic signed [VALUE_W-1:0] right_value;

      if (i == 0) begin : g_head
         assign left_lt    = 1'b1;
         assign left_value = req_chan.value;
      end else begin : g_body
         assign left_lt    = lt_vec[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_value = cell_value[i];
      end else begin : g_inner
         assign right_value = cell_value[i+1];
      end

      svt_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (count_ff > COUNT_W'(i)),
         .left_lt     (left_lt),
         .left_value  (left_value),
         .right_value (right_value),
         .lt          (lt_vec[i]),
         .eq          (eq_vec[i]),
         .value       (cell_value[i])
      );
   end

   // Response and count for the current request.
   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      popped_in = '0;
      case (op)
         OP_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         OP_SEARCH: begin
            status_in = hit ? ST_OK : ST_NOT_FOUND;
         end
         OP_DELETE: begin
            if (hit) begin
               count_in = count_ff - COUNT_W'(1);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         OP_POP: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               popped_in = cell_value[0];
               count_in  = count_ff - COUNT_W'(1);
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // Hold the response until taken; load a new one on each request transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         popped_ff    <= popped_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.popped_value = popped_ff;
   assign rsp_chan.entry_count  = ENTRY_COUNT_W'(rsp_count_ff);

   `SVT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_W'(CAPACITY), "count above capacity")
   `SVT_ASSERT_NEXT(a_rsp_after_accept, clock, reset, accept, rsp_valid_ff, "no response after request")
   `SVT_ASSERT_NEXT(a_full_keeps_count, clock, reset, accept && (op == OP_INSERT) && full, count_ff == $past(count_ff), "insert on full table changed count")
   `SVT_ASSERT_NEXT(a_insert_grows, clock, reset, cmd.ins, count_ff == COUNT_W'($past(count_ff) + COUNT_W'(1)), "insert did not grow count")

endmodule
